// ----- sv/bdq_pkg.sv -----
// shared types, constants and ring helper for the bounded deque
package bdq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_VAL  = 3'd2,
    CMD_FIND     = 3'd3,
    CMD_REM_HEAD = 3'd4,
    CMD_REM_TAIL = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_RD_HEAD,
    S_RD_TAIL,
    S_FINISH
  } state_t;

  // ring position of an offset from the head
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/bounded_deque_with_value_delete_top.sv -----
// bounded deque with delete by value: command fsm around one value ram
// usage
//   input channel: drive in_command and in_value with start high; the item
//   is taken at the clock edge where start is high and busy is low. busy
//   stays high from the cycle after that until the cycle out_valid rises.
//   result channel: out_valid is high for exactly one cycle with out_status,
//   out_count, out_head_value and out_tail_value; the receiver cannot stall,
//   so the result must be taken in that cycle.
// sequence
//   insert, remove head, remove tail, unknown codes and any command on an
//   empty list step through the dispatch, head read, tail read and finish
//   states before out_valid rises. find and remove by value walk the ram
//   one entry per cycle between dispatch and the head read: the entries
//   scanned plus, for a remove, the entries shifted toward the head, never
//   more than the entry count. a new item can be accepted in the cycle
//   out_valid is high.
// reset
//   synchronous active-low rst_n empties the list and sets the head index
//   to zero; the ram itself is not cleared since only written entries ever
//   reach the outputs.
module bounded_deque_with_value_delete_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_command,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [bdq_pkg::CNT_W-1:0]   out_count,
  output logic signed [31:0]          out_head_value,
  output logic signed [31:0]          out_tail_value
);
  import bdq_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;          // scan / shift offset from head
  logic              out_valid_r, out_valid_nxt;

  // per-command payload
  logic [2:0]        cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] head_val_r, head_val_nxt;

  // result registers
  logic [1:0]        out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [DATA_W-1:0] out_head_r, out_head_nxt;
  logic [DATA_W-1:0] out_tail_r, out_tail_nxt;

  // ram port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // shared decisions
  logic              is_empty, is_full, scan_hit, scan_last, shift_last;
  logic [IDX_W-1:0]  head_dec, head_inc;
  logic [CNT_W:0]    k_plus1, k_plus2;

  bdq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == CNT_W'(CAPACITY));
  assign k_plus1    = (CNT_W+1)'(k_r) + (CNT_W+1)'(1);
  assign k_plus2    = (CNT_W+1)'(k_r) + (CNT_W+1)'(2);
  assign scan_hit   = (ram_rdata == val_r);
  assign scan_last  = (k_plus1 == (CNT_W+1)'(count_r));
  assign shift_last = (k_plus2 == (CNT_W+1)'(count_r));
  assign head_dec   = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - IDX_W'(1);
  assign head_inc   = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if ((cmd_r == CMD_REM_VAL || cmd_r == CMD_FIND) && !is_empty) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RD_HEAD;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (cmd_r == CMD_FIND || scan_last) begin
            state_nxt = S_RD_HEAD;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (scan_last) begin
          state_nxt = S_RD_HEAD;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_nxt = S_RD_HEAD;
        end
      end
      S_RD_HEAD: state_nxt = S_RD_TAIL;
      S_RD_TAIL: state_nxt = S_FINISH;
      S_FINISH:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    head_val_nxt   = head_val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    ram_we         = 1'b0;
    ram_waddr      = slot(head_r, CNT_W'(k_r));
    ram_wdata      = val_r;
    ram_raddr      = slot(head_r, '0);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          val_nxt    = in_value;
          status_nxt = ST_OK;
        end
      end
      S_DISPATCH: begin
        case (cmd_r)
          CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (cmd_r == CMD_INS_HEAD) begin
                head_nxt  = head_dec;
                ram_waddr = head_dec;
              end else begin
                ram_waddr = slot(head_r, count_r);
              end
            end
          end
          CMD_REM_VAL, CMD_FIND: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              ram_raddr = slot(head_r, '0);
              k_nxt     = '0;
            end
          end
          CMD_REM_HEAD: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              // a one-entry list keeps its head index when emptied
              if (count_r != CNT_W'(1)) begin
                head_nxt = head_inc;
              end
            end
          end
          CMD_REM_TAIL: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // ram_rdata holds the entry at offset k_r
        if (scan_hit) begin
          if (cmd_r != CMD_FIND) begin
            if (scan_last) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              ram_raddr = slot(head_r, k_plus1[CNT_W-1:0]);
            end
          end
        end else if (scan_last) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          ram_raddr = slot(head_r, k_plus1[CNT_W-1:0]);
          k_nxt     = k_plus1[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // ram_rdata holds offset k_r + 1, moved down to k_r
        ram_we    = 1'b1;
        ram_waddr = slot(head_r, CNT_W'(k_r));
        ram_wdata = ram_rdata;
        k_nxt     = k_plus1[IDX_W-1:0];
        if (shift_last) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          ram_raddr = slot(head_r, k_plus2[CNT_W-1:0]);
        end
      end
      S_RD_HEAD: begin
        ram_raddr = slot(head_r, '0);
      end
      S_RD_TAIL: begin
        ram_raddr    = slot(head_r, count_r - CNT_W'(1));
        head_val_nxt = ram_rdata;
      end
      S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_count_nxt  = count_r;
        out_head_nxt   = is_empty ? '0 : head_val_r;
        out_tail_nxt   = is_empty ? '0 : ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    head_val_r   <= head_val_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_head_value = out_head_r;
  assign out_tail_value = out_tail_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still working");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |-> (out_head_value == '0 && out_tail_value == '0))
    else $error("empty list result carries nonzero values");

  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (k_plus2 <= (CNT_W+1)'(count_r)))
    else $error("shift ran past the list end");
`endif

endmodule

// ----- sv/bdq_ram.sv -----
// generic single write port, single read port ram with registered read
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
